### rtl/scc_pkg.sv
package scc_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int PHASE_W    = 24;
  localparam int BASE_W     = 19;
  localparam int MDEPTH_W   = 18;
  localparam int WET_W      = 16;
  localparam int VC_W       = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int D_W        = 24;

  localparam int DELAY_DEPTH_DEF = 2048;
  localparam int MAX_VOICES_DEF  = 4;
  localparam int SINE_DEPTH_DEF  = 1024;

  localparam int GAIN_FULL = 32768;
  localparam int GAIN_PAN  = 22938;
  localparam int SIN_A     = 102944;
  localparam int SIN_B     = 42334;
  localparam int SIN_C     = 4926;

  localparam int RST_VOICES = 2;
  localparam int RST_STEP   = 350;
  localparam int RST_BASE   = 86016;
  localparam int RST_DEPTH  = 18432;
  localparam int RST_WET    = 16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE, CFG_VOICES, CFG_STEP, CFG_BASE, CFG_DEPTH, CFG_WET
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_SIN, ST_MT, ST_MT2, ST_MS, ST_MD, ST_ADDR,
    ST_L0, ST_L1, ST_R0, ST_R1, ST_GL, ST_GR, ST_ACC,
    ST_DIVGO, ST_DIVW, ST_ML0, ST_ML1, ST_MR0, ST_MR1, ST_MEND, ST_FIN
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       block_end_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       block_end_out;
  } out_item_t;

endpackage

### rtl/scc_store.sv
module scc_store #(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr0,
  input  logic [ADDR_W-1:0] raddr1,
  output logic [DATA_W-1:0] rdata0,
  output logic [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem_r[raddr0];
      rdata1 <= mem_r[raddr1];
    end
  end

endmodule

### rtl/scc_mul.sv
module scc_mul #(
  parameter int AW = 33,
  parameter int BW = 19
) (
  input  logic                    clk,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] prod
);

  logic signed [AW+BW-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

### rtl/scc_div.sv
module scc_div #(
  parameter int QW  = 29,
  parameter int VCW = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VCW-1:0]        divisor,
  input  logic signed [QW-1:0]  num_l,
  input  logic signed [QW-1:0]  num_r,
  output logic                  done,
  output logic signed [QW-1:0]  quo_l,
  output logic signed [QW-1:0]  quo_r
);

  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]  u_r [2];
  logic [QW-1:0]  u_nxt [2];
  logic [VCW-1:0] rem_r [2];
  logic [VCW-1:0] rem_nxt [2];
  logic           neg_r [2];
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;
  logic signed [QW-1:0] num [2];

  assign num[0] = num_l;
  assign num[1] = num_r;

  always_comb begin
    logic [VCW:0] rem_s;
    logic         ge;
    for (int i = 0; i < 2; i++) begin
      rem_s      = {rem_r[i], u_r[i][QW-1]};
      ge         = (rem_s >= {1'b0, divisor});
      rem_nxt[i] = ge ? VCW'(rem_s - {1'b0, divisor}) : VCW'(rem_s);
      u_nxt[i]   = {u_r[i][QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 2; i++) begin
        neg_r[i] <= num[i][QW-1];
        rem_r[i] <= '0;
        u_r[i]   <= num[i][QW-1] ? ((~num[i]) + QW'(1) + QW'(divisor) - QW'(1))
                                 : num[i];
      end
    end else if (busy_r) begin
      for (int i = 0; i < 2; i++) begin
        u_r[i]   <= u_nxt[i];
        rem_r[i] <= rem_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done  = done_r;
  assign quo_l = neg_r[0] ? -$signed(u_r[0]) : $signed(u_r[0]);
  assign quo_r = neg_r[1] ? -$signed(u_r[1]) : $signed(u_r[1]);

endmodule

### rtl/stereo_multivoice_chorus_core.sv
// A sample is accepted, each active voice is then processed in turn on the shared
// multiplier, then the serial divider and the mix run, and the result is registered.
// No new sample is taken until the last one is loaded into the output register. A
// disabled block skips the voices and the mix and passes a sample unchanged to the output.
// Reset is synchronous and active low; afterwards a clearing pass zeroes every entry
// of the delay store before the first transaction is accepted.
module stereo_multivoice_chorus_core #(
  parameter int DELAY_DEPTH      = scc_pkg::DELAY_DEPTH_DEF,
  parameter int MAX_VOICES       = scc_pkg::MAX_VOICES_DEF,
  parameter int SINE_TABLE_DEPTH = scc_pkg::SINE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  scc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output scc_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [scc_pkg::CFG_IDX_W-1:0]       cfg_addr,
  input  logic [scc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import scc_pkg::*;

  localparam int AB  = $clog2(DELAY_DEPTH);
  localparam int TB  = $clog2(SINE_TABLE_DEPTH);
  localparam int VCW = $clog2(MAX_VOICES + 1);
  localparam int VIW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int AW  = SAMPLE_W + 9;
  localparam int BW  = 19;
  localparam int PW  = AW + BW;
  localparam int QW  = PW - 23;
  localparam int SW  = 2 * SAMPLE_W;
  localparam logic signed [D_W-1:0] DMIN = D_W'(256);
  localparam logic signed [D_W-1:0] DMAX = D_W'((DELAY_DEPTH - 2) * 256);
  localparam logic signed [PW-15:0] SMAX = (PW-14)'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [PW-15:0] SMIN = -SMAX - 1;

  function automatic logic signed [SAMPLE_W-1:0] sat_s(input logic signed [PW:0] v);
    logic signed [PW-15:0] sh;
    sh = v[PW:15];
    if (sh > SMAX) begin
      return SMAX[SAMPLE_W-1:0];
    end else if (sh < SMIN) begin
      return SMIN[SAMPLE_W-1:0];
    end
    return sh[SAMPLE_W-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic                 enable_r;
  logic [VC_W-1:0]      voices_r;
  logic [PHASE_W-1:0]   step_r;
  logic [BASE_W-1:0]    base_r;
  logic [MDEPTH_W-1:0]  depth_r;
  logic [WET_W-1:0]     wet_r;

  logic [AB-1:0]        wp_r, wp_nxt;
  logic [AB-1:0]        clr_r, clr_nxt;
  logic [VCW-1:0]       v_r, v_nxt;
  logic [PHASE_W-1:0]   phase_r [MAX_VOICES];
  logic [PHASE_W-1:0]   phase_nxt [MAX_VOICES];
  logic [16:0]          x_r, x_nxt, x2_r, x2_nxt;
  logic                 neg_r, neg_nxt;
  logic [7:0]           frac_r, frac_nxt;
  logic signed [AW-1:0] tl_r, tl_nxt, tr_r, tr_nxt;
  logic signed [PW-1:0] accl_r, accl_nxt, accr_r, accr_nxt, mixp_r, mixp_nxt;
  logic signed [SAMPLE_W-1:0] dryl_r, dryl_nxt, dryr_r, dryr_nxt;
  logic signed [SAMPLE_W-1:0] resl_r, resl_nxt, resr_r, resr_nxt;
  logic                 bend_r, bend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 in_fire;
  logic                 load_out;
  logic [VCW-1:0]       vce;
  logic [16:0]          mix_c, dmix_c;
  logic [PHASE_W-1:0]   cur_phase;
  logic [TB-1:0]        k_c;
  logic [15:0]          xraw_c;
  logic [16:0]          x_c, p16_c, t_c, t2_c, scap_c;
  logic [16:0]          sraw_c;
  logic signed [16:0]   ssgn_c;
  logic signed [D_W-1:0] dm_c, d_c, dcl_c, rp_c;
  logic [AB-1:0]        i0_c, i1_c;
  logic [8:0]           fw0_c, fw1_c;
  logic [BW-1:0]        gl_c, gr_c;
  logic signed [PW:0]   msum_c;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  logic                 mem_we, mem_re;
  logic [AB-1:0]        mem_waddr;
  logic [SW-1:0]        mem_wdata, rd0, rd1;
  logic signed [SAMPLE_W-1:0] rd0l, rd0r, rd1l, rd1r;

  logic                 div_start, div_done;
  logic signed [QW-1:0] quo_l, quo_r;

  scc_store #(.DEPTH(DELAY_DEPTH), .ADDR_W(AB), .DATA_W(SW)) u_store (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata), .re(mem_re),
    .raddr0(i0_c), .raddr1(i1_c), .rdata0(rd0), .rdata1(rd1)
  );

  scc_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk(clk), .a(mul_a), .b(mul_b), .prod(prod)
  );

  scc_div #(.QW(QW), .VCW(VCW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .divisor(vce),
    .num_l(accl_r[PW-1:23]), .num_r(accr_r[PW-1:23]),
    .done(div_done), .quo_l(quo_l), .quo_r(quo_r)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_out  = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign div_start = (state_r == ST_DIVGO);

  assign rd0l = rd0[SW-1:SAMPLE_W];
  assign rd0r = rd0[SAMPLE_W-1:0];
  assign rd1l = rd1[SW-1:SAMPLE_W];
  assign rd1r = rd1[SAMPLE_W-1:0];

  always_comb begin
    if (voices_r == '0) begin
      vce = VCW'(1);
    end else if (voices_r > VC_W'(MAX_VOICES)) begin
      vce = VCW'(MAX_VOICES);
    end else begin
      vce = VCW'(voices_r);
    end
  end

  assign mix_c  = (wet_r > 16'd32768) ? 17'd32768 : {1'b0, wet_r};
  assign dmix_c = 17'd32768 - mix_c;

  assign cur_phase = phase_r[v_r[VIW-1:0]];
  assign k_c       = cur_phase[PHASE_W-1 -: TB];
  assign xraw_c    = 16'(k_c[TB-3:0]) << (18 - TB);
  assign x_c       = k_c[TB-2] ? (17'h10000 - {1'b0, xraw_c}) : {1'b0, xraw_c};
  assign p16_c     = prod[32:16];
  assign t_c       = 17'(SIN_B) - p16_c;
  assign t2_c      = 17'(SIN_A) - p16_c;
  assign sraw_c    = prod[33:17];
  assign scap_c    = (sraw_c > 17'd32767) ? 17'd32767 : sraw_c;
  assign ssgn_c    = neg_r ? -$signed(scap_c) : $signed(scap_c);

  assign dm_c  = prod[15 +: D_W];
  assign d_c   = $signed(D_W'(base_r)) + dm_c;
  assign dcl_c = (d_c < DMIN) ? DMIN : ((d_c > DMAX) ? DMAX : d_c);
  assign rp_c  = $signed(D_W'({wp_r, 8'h00})) - dcl_c;
  assign i0_c  = rp_c[AB+7:8];
  assign i1_c  = i0_c + 1'b1;

  assign fw0_c = 9'd256 - {1'b0, frac_r};
  assign fw1_c = {1'b0, frac_r};
  assign gl_c  = v_r[0] ? BW'(GAIN_PAN) : BW'(GAIN_FULL);
  assign gr_c  = v_r[0] ? BW'(GAIN_FULL) : BW'(GAIN_PAN);
  assign msum_c = {prod[PW-1], prod} + {mixp_r[PW-1], mixp_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SIN: begin
        mul_a = $signed(AW'(x_c));
        mul_b = $signed(BW'(x_c));
      end
      ST_MT: begin
        mul_a = AW'(SIN_C);
        mul_b = $signed(BW'(p16_c));
      end
      ST_MT2: begin
        mul_a = $signed(AW'(t_c));
        mul_b = $signed(BW'(x2_r));
      end
      ST_MS: begin
        mul_a = $signed(AW'(t2_c));
        mul_b = $signed(BW'(x_r));
      end
      ST_MD: begin
        mul_a = AW'(ssgn_c);
        mul_b = $signed(BW'(depth_r));
      end
      ST_L0: begin
        mul_a = AW'(rd0l);
        mul_b = $signed(BW'(fw0_c));
      end
      ST_L1: begin
        mul_a = AW'(rd1l);
        mul_b = $signed(BW'(fw1_c));
      end
      ST_R0: begin
        mul_a = AW'(rd0r);
        mul_b = $signed(BW'(fw0_c));
      end
      ST_R1: begin
        mul_a = AW'(rd1r);
        mul_b = $signed(BW'(fw1_c));
      end
      ST_GL: begin
        mul_a = tl_r;
        mul_b = $signed(gl_c);
      end
      ST_GR: begin
        mul_a = tr_r;
        mul_b = $signed(gr_c);
      end
      ST_ML0: begin
        mul_a = AW'(dryl_r);
        mul_b = $signed(BW'(dmix_c));
      end
      ST_ML1: begin
        mul_a = AW'(quo_l);
        mul_b = $signed(BW'(mix_c));
      end
      ST_MR0: begin
        mul_a = AW'(dryr_r);
        mul_b = $signed(BW'(dmix_c));
      end
      ST_MR1: begin
        mul_a = AW'(quo_r);
        mul_b = $signed(BW'(mix_c));
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:   if (clr_r == {AB{1'b1}}) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_fire) state_nxt = enable_r ? ST_SIN : ST_FIN;
      ST_SIN:   state_nxt = ST_MT;
      ST_MT:    state_nxt = ST_MT2;
      ST_MT2:   state_nxt = ST_MS;
      ST_MS:    state_nxt = ST_MD;
      ST_MD:    state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_L0;
      ST_L0:    state_nxt = ST_L1;
      ST_L1:    state_nxt = ST_R0;
      ST_R0:    state_nxt = ST_R1;
      ST_R1:    state_nxt = ST_GL;
      ST_GL:    state_nxt = ST_GR;
      ST_GR:    state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ((v_r + 1'b1) < vce) ? ST_SIN : ST_DIVGO;
      ST_DIVGO: state_nxt = ST_DIVW;
      ST_DIVW:  if (div_done) state_nxt = ST_ML0;
      ST_ML0:   state_nxt = ST_ML1;
      ST_ML1:   state_nxt = ST_MR0;
      ST_MR0:   state_nxt = ST_MR1;
      ST_MR1:   state_nxt = ST_MEND;
      ST_MEND:  state_nxt = ST_FIN;
      ST_FIN:   if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    wp_nxt        = wp_r;
    clr_nxt       = clr_r;
    v_nxt         = v_r;
    phase_nxt     = phase_r;
    x_nxt         = x_r;
    x2_nxt        = x2_r;
    neg_nxt       = neg_r;
    frac_nxt      = frac_r;
    tl_nxt        = tl_r;
    tr_nxt        = tr_r;
    accl_nxt      = accl_r;
    accr_nxt      = accr_r;
    mixp_nxt      = mixp_r;
    dryl_nxt      = dryl_r;
    dryr_nxt      = dryr_r;
    resl_nxt      = resl_r;
    resr_nxt      = resr_r;
    bend_nxt      = bend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = wp_r;
    mem_wdata     = {in_data.left_in, in_data.right_in};
    unique case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_fire) begin
          dryl_nxt = in_data.left_in;
          dryr_nxt = in_data.right_in;
          bend_nxt = in_data.block_end_in;
          resl_nxt = in_data.left_in;
          resr_nxt = in_data.right_in;
          v_nxt    = '0;
          accl_nxt = '0;
          accr_nxt = '0;
          mem_we   = enable_r;
        end
      end
      ST_SIN: begin
        x_nxt   = x_c;
        neg_nxt = k_c[TB-1];
      end
      ST_MT:   x2_nxt = p16_c;
      ST_ADDR: begin
        frac_nxt = rp_c[7:0];
        mem_re   = 1'b1;
      end
      ST_L1:   tl_nxt = prod[AW-1:0];
      ST_R0:   tl_nxt = tl_r + prod[AW-1:0];
      ST_R1:   tr_nxt = prod[AW-1:0];
      ST_GL:   tr_nxt = tr_r + prod[AW-1:0];
      ST_GR:   accl_nxt = accl_r + prod;
      ST_ACC: begin
        accr_nxt = accr_r + prod;
        phase_nxt[v_r[VIW-1:0]] = cur_phase + step_r;
        v_nxt = v_r + 1'b1;
      end
      ST_DIVGO: wp_nxt = wp_r + 1'b1;
      ST_ML1:   mixp_nxt = prod;
      ST_MR0:   resl_nxt = sat_s(msum_c);
      ST_MR1:   mixp_nxt = prod;
      ST_MEND:  resr_nxt = sat_s(msum_c);
      ST_FIN: begin
        if (load_out) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.left_out      = resl_r;
          out_data_nxt.right_out     = resr_r;
          out_data_nxt.block_end_out = bend_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      wp_r        <= '0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_VOICES; i++) begin
        phase_r[i] <= PHASE_W'(i) << 22;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      wp_r        <= wp_nxt;
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    x2_r       <= x2_nxt;
    neg_r      <= neg_nxt;
    frac_r     <= frac_nxt;
    tl_r       <= tl_nxt;
    tr_r       <= tr_nxt;
    accl_r     <= accl_nxt;
    accr_r     <= accr_nxt;
    mixp_r     <= mixp_nxt;
    dryl_r     <= dryl_nxt;
    dryr_r     <= dryr_nxt;
    resl_r     <= resl_nxt;
    resr_r     <= resr_nxt;
    bend_r     <= bend_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      voices_r <= VC_W'(RST_VOICES);
      step_r   <= PHASE_W'(RST_STEP);
      base_r   <= BASE_W'(RST_BASE);
      depth_r  <= MDEPTH_W'(RST_DEPTH);
      wet_r    <= WET_W'(RST_WET);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ENABLE: enable_r <= cfg_wdata[0];
        CFG_VOICES: voices_r <= cfg_wdata[VC_W-1:0];
        CFG_STEP:   step_r   <= cfg_wdata[PHASE_W-1:0];
        CFG_BASE:   base_r   <= cfg_wdata[BASE_W-1:0];
        CFG_DEPTH:  depth_r  <= cfg_wdata[MDEPTH_W-1:0];
        CFG_WET:    wet_r    <= cfg_wdata[WET_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
